// ===== rtl/ita_pkg.sv =====
// Shared types and constants for the integer to ASCII formatter.
// Used by the interfaces, controller, datapath, top level and checker.
package ita_pkg;

    localparam int ITA_COUNT_WIDTH = 32;
    localparam int ITA_VALUE_WIDTH = 64;
    localparam int ITA_TOTAL_WIDTH = 32;
    localparam int ITA_BIN_WIDTH   = 32;
    localparam int ITA_BCD_DIGITS  = 10;
    localparam int ITA_BCD_WIDTH   = 4 * ITA_BCD_DIGITS;
    localparam int ITA_HEX_DIGITS  = ITA_VALUE_WIDTH / 4;

    localparam logic [2:0] REQ_SDEC   = 3'd0;
    localparam logic [2:0] REQ_UDEC   = 3'd1;
    localparam logic [2:0] REQ_HEX_LO = 3'd2;
    localparam logic [2:0] REQ_HEX_UP = 3'd3;
    localparam logic [2:0] REQ_PTR    = 3'd4;

    localparam logic [1:0] SEL_DIGIT = 2'd0;
    localparam logic [1:0] SEL_MINUS = 2'd1;
    localparam logic [1:0] SEL_ZERO  = 2'd2;
    localparam logic [1:0] SEL_X     = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_LOW_A = 8'd97;
    localparam logic [7:0] CH_UP_A  = 8'd65;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_X     = 8'd120;

    typedef struct packed {
        logic       load;
        logic       conv_step;
        logic       load_bcd;
        logic       shift;
        logic       emit;
        logic [1:0] sel;
        logic       last;
    } ita_cmd_t;

    typedef struct packed {
        logic in_legal;
        logic in_decimal;
        logic conv_last;
        logic skip_ok;
        logic dig_last;
        logic neg;
        logic ptr;
        logic out_free;
    } ita_stat_t;

endpackage

// ===== rtl/ita_in_if.sv =====
// Input request channel of the formatter: request type and value.
// Depends on nothing but the shared package for widths.
interface ita_in_if;
    import ita_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [2:0]                 req_type;
    logic [ITA_VALUE_WIDTH-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink (input valid, input req_type, input value, output ready);
endinterface

// ===== rtl/ita_out_if.sv =====
// Output character channel of the formatter.
// Depends on the shared package for widths.
interface ita_out_if;
    import ita_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [7:0]                 ascii_char;
    logic                       last;
    logic [ITA_TOTAL_WIDTH-1:0] total_count;

    modport source (output valid, output ascii_char, output last, output total_count,
                    input ready);
    modport sink (input valid, input ascii_char, input last, input total_count,
                  output ready);
endinterface

// ===== rtl/ita_ctrl.sv =====
// Sequencing state machine of the formatter.
// Depends on ita_pkg; drives the datapath only through ita_cmd_t.
module ita_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ita_pkg::ita_stat_t stat,
    output ita_pkg::ita_cmd_t  cmd
);
    import ita_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_SKIP = 3'd3;
    localparam logic [2:0] S_PRE0 = 3'd4;
    localparam logic [2:0] S_PRE1 = 3'd5;
    localparam logic [2:0] S_DIG  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.in_legal)
                    begin
                        state_next = stat.in_decimal ? S_CONV : S_SKIP;
                    end
                end
            end
            S_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (stat.conv_last)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_bcd = 1'b1;
                state_next   = S_SKIP;
            end
            S_SKIP:
            begin
                if (stat.skip_ok)
                begin
                    cmd.shift = 1'b1;
                end
                else if (stat.neg || stat.ptr)
                begin
                    state_next = S_PRE0;
                end
                else
                begin
                    state_next = S_DIG;
                end
            end
            S_PRE0:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = stat.neg ? SEL_MINUS : SEL_ZERO;
                    state_next = stat.ptr ? S_PRE1 : S_DIG;
                end
            end
            S_PRE1:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_X;
                    state_next = S_DIG;
                end
            end
            S_DIG:
            begin
                if (stat.out_free)
                begin
                    cmd.emit  = 1'b1;
                    cmd.sel   = SEL_DIGIT;
                    cmd.shift = 1'b1;
                    cmd.last  = stat.dig_last;
                    if (stat.dig_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ita_dp.sv =====
// Datapath of the formatter: binary to BCD shifter, digit register,
// character select, running count and output register. Depends on ita_pkg.
module ita_dp
#(
    parameter int COUNT_WIDTH = ita_pkg::ITA_COUNT_WIDTH
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [2:0]                          req_type,
    input  logic [ita_pkg::ITA_VALUE_WIDTH-1:0] value,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [7:0]                          ascii_char,
    output logic                                last,
    output logic [ita_pkg::ITA_TOTAL_WIDTH-1:0] total_count,
    input  ita_pkg::ita_cmd_t                   cmd,
    output ita_pkg::ita_stat_t                  stat
);
    import ita_pkg::*;

    localparam int TW = (COUNT_WIDTH < ITA_TOTAL_WIDTH) ? COUNT_WIDTH : ITA_TOTAL_WIDTH;
    localparam int REM_W = $clog2(ITA_HEX_DIGITS + 1);
    localparam int BIT_W = $clog2(ITA_BIN_WIDTH);

    logic                       neg_reg;
    logic                       ptr_reg;
    logic                       upper_reg;
    logic [ITA_BIN_WIDTH-1:0]   bin_reg;
    logic [ITA_BCD_WIDTH-1:0]   bcd_reg;
    logic [BIT_W-1:0]           bit_cnt_reg;
    logic [ITA_VALUE_WIDTH-1:0] dig_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [COUNT_WIDTH-1:0]     count_reg;
    logic                       out_valid_reg;
    logic [7:0]                 char_reg;
    logic                       last_reg;
    logic [ITA_TOTAL_WIDTH-1:0] total_reg;

    logic [ITA_BIN_WIDTH-1:0]   low_word;
    logic [ITA_BIN_WIDTH-1:0]   mag_word;
    logic                       in_neg;
    logic [ITA_BCD_WIDTH-1:0]   bcd_adj;
    logic [3:0]                 top_nib;
    logic [7:0]                 dig_char;
    logic [7:0]                 char_next;
    logic [COUNT_WIDTH-1:0]     count_next;

    assign low_word = value[ITA_BIN_WIDTH-1:0];
    assign in_neg   = (req_type == REQ_SDEC) && low_word[ITA_BIN_WIDTH-1];
    assign mag_word = in_neg ? (~low_word + 1'b1) : low_word;
    assign top_nib  = dig_reg[ITA_VALUE_WIDTH-1 -: 4];

    always_comb
    begin
        for (int i = 0; i < ITA_BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        if (top_nib <= 4'd9)
        begin
            dig_char = CH_ZERO + {4'd0, top_nib};
        end
        else
        begin
            dig_char = (upper_reg ? CH_UP_A : CH_LOW_A) + {4'd0, top_nib} - 8'd10;
        end
        case (cmd.sel)
            SEL_DIGIT: char_next = dig_char;
            SEL_MINUS: char_next = CH_MINUS;
            SEL_ZERO:  char_next = CH_ZERO;
            SEL_X:     char_next = CH_X;
            default:   char_next = dig_char;
        endcase
    end

    assign count_next = count_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg     <= in_neg;
            ptr_reg     <= (req_type == REQ_PTR);
            upper_reg   <= (req_type == REQ_HEX_UP);
            bin_reg     <= mag_word;
            bcd_reg     <= '0;
            bit_cnt_reg <= '0;
            dig_reg     <= value;
            rem_reg     <= REM_W'(ITA_HEX_DIGITS);
        end
        else if (cmd.conv_step)
        begin
            bcd_reg     <= {bcd_adj[ITA_BCD_WIDTH-2:0], bin_reg[ITA_BIN_WIDTH-1]};
            bin_reg     <= {bin_reg[ITA_BIN_WIDTH-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + 1'b1;
        end
        else if (cmd.load_bcd)
        begin
            dig_reg <= {bcd_reg, {(ITA_VALUE_WIDTH - ITA_BCD_WIDTH){1'b0}}};
            rem_reg <= REM_W'(ITA_BCD_DIGITS);
        end
        else if (cmd.shift)
        begin
            dig_reg <= {dig_reg[ITA_VALUE_WIDTH-5:0], 4'd0};
            rem_reg <= rem_reg - 1'b1;
        end
        if (cmd.emit)
        begin
            char_reg  <= char_next;
            last_reg  <= cmd.last;
            total_reg <= ITA_TOTAL_WIDTH'(count_next[TW-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.in_legal   = (req_type <= REQ_PTR);
        stat.in_decimal = (req_type inside {REQ_SDEC, REQ_UDEC});
        stat.conv_last  = (bit_cnt_reg == BIT_W'(ITA_BIN_WIDTH - 1));
        stat.skip_ok    = (top_nib == 4'd0) && (rem_reg > REM_W'(1));
        stat.dig_last   = (rem_reg == REM_W'(1));
        stat.neg        = neg_reg;
        stat.ptr        = ptr_reg;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign ascii_char  = char_reg;
    assign last        = last_reg;
    assign total_count = total_reg;

endmodule

// ===== rtl/integer_to_ascii_formatter_top.sv =====
// Each request formats one number and delivers it as ASCII characters, most significant
// first, one character per cycle while the output side is ready. Decimal requests first
// run a shift-and-add-3 conversion and then a load step; hex and pointer requests
// start at once. Leading zero digits are then dropped at one digit per cycle (up to 9
// decimal or 15 hex). A new request is taken once the last character of the previous
// one is in the output register. Unused request types are taken and produce no
// characters. The count wraps at COUNT_WIDTH bits.
// Depends on ita_pkg, ita_in_if, ita_out_if, ita_ctrl and ita_dp.
module integer_to_ascii_formatter_top
#(
    parameter int COUNT_WIDTH = ita_pkg::ITA_COUNT_WIDTH
)
(
    input logic clk,
    input logic rst_n,
    ita_in_if.sink    in,
    ita_out_if.source out
);
    import ita_pkg::*;

    ita_cmd_t  cmd;
    ita_stat_t stat;
    logic      in_ready;

    assign in.ready = in_ready;

    ita_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ita_dp
    #(
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_type    (in.req_type),
        .value       (in.value),
        .out_ready   (out.ready),
        .out_valid   (out.valid),
        .ascii_char  (out.ascii_char),
        .last        (out.last),
        .total_count (out.total_count),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ===== rtl/ita_checker.sv =====
// Port-level checks for the formatter, attached to the top level by bind.
// Depends on ita_pkg and integer_to_ascii_formatter_top.
module ita_checker
#(
    parameter int COUNT_WIDTH = ita_pkg::ITA_COUNT_WIDTH
)
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                out_last,
    input logic [ita_pkg::ITA_TOTAL_WIDTH-1:0] out_total
);
    import ita_pkg::*;

    localparam int TW = (COUNT_WIDTH < ITA_TOTAL_WIDTH) ? COUNT_WIDTH : ITA_TOTAL_WIDTH;

    logic                       seen_reg;
    logic                       run_reg;
    logic [TW-1:0]              prev_reg;
    logic [TW-1:0]              expect_cnt;
    logic                       out_acc;

    assign out_acc    = out_valid && out_ready;
    assign expect_cnt = seen_reg ? (prev_reg + 1'b1) : TW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            run_reg  <= 1'b0;
            prev_reg <= '0;
        end
        else if (out_acc)
        begin
            seen_reg <= 1'b1;
            run_reg  <= !out_last;
            prev_reg <= out_total[TW-1:0];
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Output request dropped before it was taken.");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> out_total == ITA_TOTAL_WIDTH'(expect_cnt))
        else $error("Character count did not advance by one.");

    a_no_input_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg && !(out_valid && out_last) |-> !(in_valid && in_ready))
        else $error("Input taken while a character run was unfinished.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_last) && $stable(out_total))
        else $error("Output request changed while it was waiting.");

endmodule

bind integer_to_ascii_formatter_top ita_checker
#(
    .COUNT_WIDTH (COUNT_WIDTH)
)
u_ita_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .out_last  (out.last),
    .out_total (out.total_count)
);
